// ----- hdl/tlv_pkg.sv -----
// Shared types and constants for the record field parser.
package tlv_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned FIFO_DEP = 4;
  localparam int unsigned PTR_W    = $clog2(FIFO_DEP);
  localparam int unsigned CNT_W    = $clog2(FIFO_DEP + 1);

  localparam logic [LEN_W-1:0]  LEN_TERM   = 16'hFFFF;
  localparam logic [BYTE_W-1:0] TYPE_NOTES = 8'hFF;
  localparam logic [BYTE_W-1:0] TYPE_PASS  = 8'd2;

  typedef enum logic [2:0] {
    PH_LEN_HI = 3'd0,
    PH_LEN_LO = 3'd1,
    PH_TYPE   = 3'd2,
    PH_RSVD   = 3'd3,
    PH_DATA   = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NAME  = 3'd0,
    KIND_ACCT  = 3'd1,
    KIND_PASS  = 3'd2,
    KIND_NOTES = 3'd3,
    KIND_SKIP  = 3'd4
  } kind_t;

  typedef struct packed {
    logic [1:0]        field_kind;
    logic [BYTE_W-1:0] data_byte;
    logic              has_data;
    logic              field_end;
    logic              record_done;
    logic              status;
  } result_t;

  localparam result_t RES_ZERO = '0;

endpackage

// ----- hdl/tlv_record_field_parser.sv -----
// Record field parser: header decode, data emit and result queue.
// Throughput: one input word per cycle unless in_stall; a word that causes two
//   results (underflow close) fills two slots of the 4-entry result queue, which
//   drains one result per cycle unless out_stall, and in_stall rises while fewer
//   than two slots are free. Results are registered into the queue.
// Reset: synchronous, active low; clears the parse state and empties the queue.
module tlv_record_field_parser (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [tlv_pkg::BYTE_W-1:0] in_byte_in,
  input  logic                     in_record_last,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_field_kind,
  output logic [tlv_pkg::BYTE_W-1:0] out_data_byte,
  output logic                     out_has_data,
  output logic                     out_field_end,
  output logic                     out_record_done,
  output logic                     out_status
);
  import tlv_pkg::*;

  phase_t                phase_r, phase_nxt;
  logic [LEN_W-1:0]      flen_r, flen_nxt;
  logic [LEN_W-1:0]      bcnt_r, bcnt_nxt;
  kind_t                 kind_r, kind_nxt;
  logic [BYTE_W-1:0]     fbyte_r, fbyte_nxt;

  result_t               fifo_r [FIFO_DEP];
  logic [PTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]      count_r;

  logic                  in_acc, out_acc;
  logic [LEN_W:0]        padded;
  logic [LEN_W:0]        idx_inc;
  logic [LEN_W-1:0]      len_word;
  logic                  known;
  logic                  closed;
  result_t               res0, res1;
  logic [1:0]            push_n;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign in_stall = count_r > CNT_W'(FIFO_DEP - 2);
  assign out_valid = count_r != '0;

  assign padded   = ({1'b0, flen_r} + (LEN_W+1)'(1)) & {1'b0, {(LEN_W-1){1'b1}}, 1'b0};
  assign idx_inc  = {1'b0, bcnt_r} + (LEN_W+1)'(1);
  assign len_word = {fbyte_r, in_byte_in};
  assign known    = kind_r != KIND_SKIP;

  // Phase and counter update.
  always_comb begin
    phase_nxt = phase_r;
    flen_nxt  = flen_r;
    bcnt_nxt  = bcnt_r;
    kind_nxt  = kind_r;
    fbyte_nxt = fbyte_r;
    unique case (phase_r)
      PH_LEN_HI: begin
        fbyte_nxt = in_byte_in;
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        flen_nxt  = len_word;
        phase_nxt = (len_word == LEN_TERM) ? PH_DONE : PH_TYPE;
      end
      PH_TYPE: begin
        priority if (in_byte_in <= TYPE_PASS) begin
          kind_nxt = kind_t'(in_byte_in[KIND_W-1:0]);
        end else if (in_byte_in == TYPE_NOTES) begin
          kind_nxt = KIND_NOTES;
        end else begin
          kind_nxt = KIND_SKIP;
        end
        phase_nxt = PH_RSVD;
      end
      PH_RSVD: begin
        bcnt_nxt  = '0;
        phase_nxt = (padded == '0) ? PH_LEN_HI : PH_DATA;
      end
      PH_DATA: begin
        bcnt_nxt = idx_inc[LEN_W-1:0];
        if (idx_inc >= padded) begin
          phase_nxt = PH_LEN_HI;
        end
      end
      default: begin
      end
    endcase
    // End of buffer: return to the reset state.
    if (in_record_last) begin
      phase_nxt = PH_LEN_HI;
      flen_nxt  = '0;
      bcnt_nxt  = '0;
      kind_nxt  = KIND_SKIP;
      fbyte_nxt = '0;
    end
  end

  // Result generation.
  always_comb begin
    res0   = RES_ZERO;
    res1   = RES_ZERO;
    push_n = 2'd0;
    closed = 1'b0;
    unique case (phase_r)
      PH_LEN_HI, PH_TYPE: begin
      end
      PH_LEN_LO: begin
        if (len_word == LEN_TERM) begin
          res0.record_done = 1'b1;
          push_n = 2'd1;
          closed = 1'b1;
        end
      end
      PH_RSVD: begin
        if (padded == '0 && known) begin
          res0.field_kind = kind_r[1:0];
          res0.field_end  = 1'b1;
          push_n = 2'd1;
        end
      end
      PH_DATA: begin
        if (known && ({1'b0, bcnt_r} < {1'b0, flen_r})) begin
          res0.field_kind = kind_r[1:0];
          res0.data_byte  = in_byte_in;
          res0.has_data   = 1'b1;
          res0.field_end  = idx_inc == {1'b0, flen_r};
          push_n = 2'd1;
        end
      end
      default: begin
        closed = 1'b1;
      end
    endcase
    // Underflow close follows whatever this word produced.
    if (in_record_last && !closed) begin
      if (push_n == 2'd0) begin
        res0.record_done = 1'b1;
        res0.status      = 1'b1;
      end else begin
        res1.record_done = 1'b1;
        res1.status      = 1'b1;
      end
      push_n = push_n + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEN_HI;
      flen_r  <= '0;
      bcnt_r  <= '0;
      kind_r  <= KIND_SKIP;
      fbyte_r <= '0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      flen_r  <= flen_nxt;
      bcnt_r  <= bcnt_nxt;
      kind_r  <= kind_nxt;
      fbyte_r <= fbyte_nxt;
    end
  end

  logic [1:0] push_eff;
  assign push_eff = in_acc ? push_n : 2'd0;

  always_ff @(posedge clk) begin
    if (push_eff != 2'd0) begin
      fifo_r[wr_ptr_r] <= res0;
    end
    if (push_eff == 2'd2) begin
      fifo_r[wr_ptr_r + PTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(push_eff);
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_r + CNT_W'(push_eff) - CNT_W'(out_acc);
    end
  end

  result_t head;
  assign head            = fifo_r[rd_ptr_r];
  assign out_field_kind  = head.field_kind;
  assign out_data_byte   = head.data_byte;
  assign out_has_data    = head.has_data;
  assign out_field_end   = head.field_end;
  assign out_record_done = head.record_done;
  assign out_status      = head.status;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(FIFO_DEP))
    else $error("result queue overflow");

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_record_last |=> phase_r == PH_LEN_HI && kind_r == KIND_SKIP)
    else $error("state not cleared after final word");

  a_done_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_done |-> !out_has_data && !out_field_end)
    else $error("closing result carries data");

  a_room_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> count_r <= CNT_W'(FIFO_DEP - 2))
    else $error("word accepted without room for two results");

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the record field parser with a byte-level predictor.
`timescale 1ns / 1ps

module testbench;
  import tlv_pkg::*;

  localparam logic [7:0] TYPE_NAME  = 8'd0;
  localparam logic [7:0] TYPE_ACCT  = 8'd1;
  localparam logic [7:0] TYPE_OTHER = 8'h80;
  localparam int         WATCHDOG_LIMIT = 500;
  localparam int         DRAIN_CYCLES   = 20;
  localparam int         TARGET_WORDS   = 1900;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  typedef struct {
    logic [7:0] b;
    logic       last;
    bit         hold;
  } in_word_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [BYTE_W-1:0]   in_byte_in = '0;
  logic                in_record_last = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          out_field_kind;
  logic [BYTE_W-1:0]   out_data_byte;
  logic                out_has_data;
  logic                out_field_end;
  logic                out_record_done;
  logic                out_status;

  tlv_record_field_parser uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_byte_in(in_byte_in), .in_record_last(in_record_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_field_kind(out_field_kind), .out_data_byte(out_data_byte),
    .out_has_data(out_has_data), .out_field_end(out_field_end),
    .out_record_done(out_record_done), .out_status(out_status)
  );

  in_word_t    pending_words[$];
  logic [7:0]  record_bytes[$];
  result_t     expected_results[$];
  int          mismatches = 0;
  logic        word_taken = 1'b0;

  // Parser state mirror
  phase_t      ps = PH_LEN_HI;
  logic [15:0] fld_len = '0;
  logic [15:0] data_idx = '0;
  kind_t       kind = KIND_SKIP;
  logic [7:0]  len_hi = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic clear_parse_state();
    ps = PH_LEN_HI;
    fld_len = '0;
    data_idx = '0;
    kind = KIND_SKIP;
    len_hi = '0;
  endtask

  task automatic push_result(logic [1:0] k, logic [7:0] d, logic has, logic fend,
                             logic done, logic st);
    result_t r;
    r.field_kind = k;
    r.data_byte = d;
    r.has_data = has;
    r.field_end = fend;
    r.record_done = done;
    r.status = st;
    expected_results.push_back(r);
  endtask

  // Advance the mirror by one accepted word and queue what it produces.
  task automatic parse_byte(logic [7:0] b, logic last);
    logic        closed;
    logic [15:0] padded;
    logic [16:0] next_idx;
    closed = 1'b0;
    padded = fld_len + 16'd1;
    padded[0] = 1'b0;
    case (ps)
      PH_LEN_HI: begin
        len_hi = b;
        ps = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        fld_len = {len_hi, b};
        if (fld_len == LEN_TERM) begin
          push_result(2'd0, 8'd0, 1'b0, 1'b0, 1'b1, 1'b0);
          closed = 1'b1;
          ps = PH_DONE;
        end else begin
          ps = PH_TYPE;
        end
      end
      PH_TYPE: begin
        if (b <= TYPE_PASS) kind = kind_t'(b[KIND_W-1:0]);
        else if (b == TYPE_NOTES) kind = KIND_NOTES;
        else kind = KIND_SKIP;
        ps = PH_RSVD;
      end
      PH_RSVD: begin
        data_idx = '0;
        if (padded == 16'd0) begin
          if (kind != KIND_SKIP) push_result(kind[1:0], 8'd0, 1'b0, 1'b1, 1'b0, 1'b0);
          ps = PH_LEN_HI;
        end else begin
          ps = PH_DATA;
        end
      end
      PH_DATA: begin
        next_idx = {1'b0, data_idx} + 17'd1;
        if (kind != KIND_SKIP && data_idx < fld_len)
          push_result(kind[1:0], b, 1'b1, next_idx == {1'b0, fld_len}, 1'b0, 1'b0);
        data_idx = next_idx[15:0];
        if (next_idx >= {1'b0, padded}) ps = PH_LEN_HI;
      end
      default: closed = 1'b1;
    endcase
    if (last) begin
      if (!closed) push_result(2'd0, 8'd0, 1'b0, 1'b0, 1'b1, 1'b1);
      clear_parse_state();
    end
  endtask

  // Stimulus builders
  task automatic add_field(int len, logic [7:0] ftype);
    record_bytes.push_back(len[15:8]);
    record_bytes.push_back(len[7:0]);
    record_bytes.push_back(ftype);
    record_bytes.push_back(8'($urandom_range(0, 255)));
    for (int i = 0; i < len + (len % 2); i++)
      record_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_terminator();
    record_bytes.push_back(LEN_TERM[15:8]);
    record_bytes.push_back(LEN_TERM[7:0]);
  endtask

  task automatic close_record(bit hold);
    in_word_t w;
    for (int i = 0; i < record_bytes.size(); i++) begin
      w.b = record_bytes[i];
      w.last = (i == record_bytes.size() - 1);
      w.hold = hold && (i == 0);
      pending_words.push_back(w);
    end
    record_bytes.delete();
  endtask

  task automatic add_random_record(bit hold);
    int kind_sel;
    int len;
    int nfields;
    int keep;
    int shape;
    logic [7:0] ftype;
    shape = $urandom_range(0, 9);
    if (shape == 9) begin
      // raw noise
      repeat ($urandom_range(1, 12)) record_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      nfields = $urandom_range(0, 4);
      repeat (nfields) begin
        if ($urandom_range(0, 15) == 0) len = $urandom_range(10, 60);
        else if ($urandom_range(0, 3) == 0) len = 0;
        else len = $urandom_range(1, 9);
        kind_sel = $urandom_range(0, 5);
        if (kind_sel <= 2) ftype = 8'(kind_sel);
        else if (kind_sel == 3) ftype = TYPE_NOTES;
        else ftype = 8'($urandom_range(3, 254));
        add_field(len, ftype);
      end
      if ($urandom_range(0, 19) < 17) begin
        add_terminator();
        repeat ($urandom_range(0, 3)) record_bytes.push_back(8'($urandom_range(0, 255)));
      end
      if (shape >= 7 && record_bytes.size() > 1) begin
        // cut the record short somewhere inside
        keep = $urandom_range(1, record_bytes.size() - 1);
        while (record_bytes.size() > keep) void'(record_bytes.pop_back());
      end
      if (record_bytes.size() == 0) record_bytes.push_back(8'($urandom_range(0, 255)));
    end
    close_record(hold);
  endtask

  // Sender: bursts with random gaps
  int  burst_left = 1;
  int  gap_left = 0;
  in_word_t cur_word;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_words.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending_words[0].hold && expected_results.size() != 0) begin
        in_valid <= 1'b0;
      end else begin
        cur_word = pending_words.pop_front();
        in_valid <= 1'b1;
        in_byte_in <= cur_word.b;
        in_record_last <= cur_word.last;
        burst_left = burst_left - 1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end
      end
    end
  end

  // Receiver stall pattern
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;
  int          tick = 0;

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(50, 300);
    end
    stall_left = stall_left - 1;
    tick = tick + 1;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= ((tick % 5) < 2);
    endcase
  end

  // Monitor, scoreboard and watchdog
  result_t got;
  result_t want;
  int      idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) parse_byte(in_byte_in, in_record_last);
      if (out_valid && !out_stall) begin
        got.field_kind = out_field_kind;
        got.data_byte = out_data_byte;
        got.has_data = out_has_data;
        got.field_end = out_field_end;
        got.record_done = out_record_done;
        got.status = out_status;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result kind=%0d data=%h has=%b end=%b done=%b st=%b",
                     $realtime, got.field_kind, got.data_byte, got.has_data,
                     got.field_end, got.record_done, got.status);
        end else begin
          want = expected_results.pop_front();
          if (got.field_kind != want.field_kind || got.data_byte != want.data_byte ||
              got.has_data != want.has_data || got.field_end != want.field_end ||
              got.record_done != want.record_done || got.status != want.status) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: want kind=%0d data=%h has=%b end=%b done=%b st=%b", $realtime,
                       want.field_kind, want.data_byte, want.has_data,
                       want.field_end, want.record_done, want.status);
              $display("%0t: got  kind=%0d data=%h has=%b end=%b done=%b st=%b", $realtime,
                       got.field_kind, got.data_byte, got.has_data,
                       got.field_end, got.record_done, got.status);
            end
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int next_hold_at;
    // odd-length notes field, empty name field, terminator, ignored tail
    add_field(1, TYPE_NOTES);
    add_field(0, TYPE_NAME);
    add_terminator();
    record_bytes.push_back(8'h00);
    record_bytes.push_back(8'hFF);
    close_record(1'b0);
    // underflow on a data byte: data result and close in one step
    add_field(2, TYPE_ACCT);
    close_record(1'b0);
    // terminator on the final byte
    add_terminator();
    close_record(1'b0);
    // empty skipped field, empty password field, underflow inside a header
    add_field(0, TYPE_OTHER);
    add_field(0, TYPE_PASS);
    record_bytes.push_back(8'h7F);
    close_record(1'b0);
    // random records; pause for a full drain every few hundred words
    next_hold_at = pending_words.size();
    while (pending_words.size() < TARGET_WORDS) begin
      add_random_record(pending_words.size() >= next_hold_at);
      if (pending_words.size() >= next_hold_at) next_hold_at = next_hold_at + 450;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      mismatches = mismatches + expected_results.size();
      $display("%0d expected results never arrived", expected_results.size());
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/tlv_pkg.sv
hdl/tlv_record_field_parser.sv
sim/testbench.sv
